>>> hw/rtl/ofa_pkg.sv
package ofa_pkg;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      STATUS_QUERY  = 2'd0,
      STATUS_ACCEPT = 2'd1,
      STATUS_REJECT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_OVERRIDE_ENABLE = 2'd0,
      CSR_TIMEOUT_MS      = 2'd1,
      CSR_EXPECTED_LENGTH = 2'd2
   } csr_index_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic        RESET_OVERRIDE_ENABLE = 1'b1;
   localparam logic [15:0] RESET_TIMEOUT_MS      = 16'd500;
   localparam logic [3:0]  RESET_EXPECTED_LENGTH = 4'd5;

   localparam logic [7:0]         FLAG_RSVD_MASK = 8'hFE;
   localparam logic [7:0]         THR_MAX        = 8'd100;
   localparam logic signed [15:0] STEER_MIN      = -16'sd300;
   localparam logic signed [15:0] STEER_MAX      = 16'sd300;
   localparam logic [7:0]         SEQ_DELTA_MAX  = 8'd127;

   typedef struct packed {
      logic        override_enable;
      logic [15:0] timeout_ms;
      logic [3:0]  expected_length;
   } cfg_type;

   typedef struct packed {
      logic               opcode;
      logic [31:0]        now_ms;
      logic [3:0]         frame_length;
      logic [7:0]         flags_byte;
      logic [7:0]         throttle_byte;
      logic [7:0]         steer_low;
      logic [7:0]         steer_high;
      logic [7:0]         sequence_byte;
      logic [9:0]         local_throttle;
      logic signed [15:0] local_steer;
   } item_type;

   typedef struct packed {
      logic [31:0]       rx_time;
      logic [31:0]       accept_count;
      logic [31:0]       reject_count;
      logic [6:0]        held_throttle;
      logic signed [9:0] held_steer;
      logic              held_flag;
      logic [7:0]        held_sequence;
      logic              sequence_known;
   } state_type;

   typedef struct packed {
      status_type         frame_status;
      logic               remote_active;
      logic [9:0]         throttle_out;
      logic signed [15:0] steer_out;
      logic [31:0]        accepted_count;
      logic [31:0]        rejected_count;
      logic [31:0]        last_rx_time;
      logic [7:0]         last_sequence;
      logic               last_flag;
   } result_type;

endpackage

>>> hw/rtl/ofa_csr.sv
module ofa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ofa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ofa_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output ofa_pkg::cfg_type                    cfg
);
   import ofa_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.override_enable <= RESET_OVERRIDE_ENABLE;
         cfg_ff.timeout_ms      <= RESET_TIMEOUT_MS;
         cfg_ff.expected_length <= RESET_EXPECTED_LENGTH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_OVERRIDE_ENABLE: cfg_ff.override_enable <= csr_wdata[0];
            CSR_TIMEOUT_MS:      cfg_ff.timeout_ms      <= csr_wdata[15:0];
            CSR_EXPECTED_LENGTH: cfg_ff.expected_length <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

endmodule

>>> hw/rtl/ofa_eval.sv
module ofa_eval (
   input  ofa_pkg::cfg_type    cfg,
   input  ofa_pkg::state_type  st,
   input  ofa_pkg::item_type   item,
   output ofa_pkg::state_type  st_next,
   output ofa_pkg::result_type res
);
   import ofa_pkg::*;

   logic signed [15:0] steer_raw;
   logic [7:0]         seq_delta;
   logic               seq_bad;
   logic               frame_ok;
   logic [31:0]        elapsed;
   logic               active;
   logic [9:0]         thr_scaled;

   always_comb begin
      steer_raw = signed'({item.steer_high, item.steer_low});
      seq_delta = item.sequence_byte - st.held_sequence;
      seq_bad   = item.flags_byte[0] && st.sequence_known &&
                  (seq_delta == 8'd0 || seq_delta > SEQ_DELTA_MAX);
      frame_ok  = cfg.override_enable &&
                  (item.frame_length == cfg.expected_length) &&
                  ((item.flags_byte & FLAG_RSVD_MASK) == 8'd0) &&
                  (item.throttle_byte <= THR_MAX) &&
                  (steer_raw >= STEER_MIN) && (steer_raw <= STEER_MAX) &&
                  !seq_bad;

      st_next          = st;
      res.frame_status = STATUS_QUERY;
      if (item.opcode == OP_FRAME) begin
         if (frame_ok) begin
            st_next.held_flag      = item.flags_byte[0];
            st_next.held_throttle  = item.throttle_byte[6:0];
            st_next.held_steer     = steer_raw[9:0];
            st_next.held_sequence  = item.sequence_byte;
            st_next.sequence_known = 1'b1;
            st_next.rx_time        = item.now_ms;
            st_next.accept_count   = st.accept_count + 32'd1;
            res.frame_status       = STATUS_ACCEPT;
         end else begin
            st_next.reject_count = st.reject_count + 32'd1;
            res.frame_status     = STATUS_REJECT;
         end
      end

      elapsed    = item.now_ms - st_next.rx_time;
      active     = cfg.override_enable && st_next.sequence_known && st_next.held_flag &&
                   (elapsed < {16'd0, cfg.timeout_ms});
      // x10 as x8 + x2
      thr_scaled = {st_next.held_throttle, 3'b000} + {2'b00, st_next.held_throttle, 1'b0};

      res.remote_active   = active;
      res.throttle_out    = active ? thr_scaled : item.local_throttle;
      res.steer_out       = active ? {{6{st_next.held_steer[9]}}, st_next.held_steer}
                                   : item.local_steer;
      res.accepted_count  = st_next.accept_count;
      res.rejected_count  = st_next.reject_count;
      res.last_rx_time    = st_next.rx_time;
      res.last_sequence   = st_next.held_sequence;
      res.last_flag       = st_next.held_flag;
   end

endmodule

>>> hw/rtl/override_frame_arbiter_core.sv
// Override frame arbiter: each transaction is a remote override frame or a query with a
// millisecond timestamp; frames are validated (override enabled, length, reserved flags,
// throttle, steering range, sequence advance) and latched when good, and every transaction
// returns one result that selects remote or local throttle/steering and reports the
// counters after that transaction. Throughput is one transaction per cycle while the
// result side does not stall. The result is registered: a transaction is captured in the
// input register, then validated and the state updated into the result register. The
// latched frame state is updated as each transaction is evaluated, so the next transaction
// sees it. csr_ready is always high; write configuration only while no transaction is in
// flight.
module override_frame_arbiter_core (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic [31:0]                      req_now_ms,
   input  logic [3:0]                       req_frame_length,
   input  logic [7:0]                       req_flags_byte,
   input  logic [7:0]                       req_throttle_byte,
   input  logic [7:0]                       req_steer_low,
   input  logic [7:0]                       req_steer_high,
   input  logic [7:0]                       req_sequence_byte,
   input  logic [9:0]                       req_local_throttle,
   input  logic signed [15:0]               req_local_steer,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_frame_status,
   output logic                             rsp_remote_active,
   output logic [9:0]                       rsp_throttle_out,
   output logic signed [15:0]               rsp_steer_out,
   output logic [31:0]                      rsp_accepted_count,
   output logic [31:0]                      rsp_rejected_count,
   output logic [31:0]                      rsp_last_rx_time,
   output logic [7:0]                       rsp_last_sequence,
   output logic                             rsp_last_flag,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ofa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ofa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ofa_pkg::*;

   cfg_type    cfg;
   item_type   in_ff;
   logic       in_valid_ff;
   state_type  st_ff;
   state_type  st_in;
   result_type res_in;
   result_type rsp_ff;
   logic       rsp_valid_ff;

   logic out_free;
   logic eval;
   logic in_free;
   logic req_take;

   ofa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ofa_eval u_eval (
      .cfg     (cfg),
      .st      (st_ff),
      .item    (in_ff),
      .st_next (st_in),
      .res     (res_in)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign eval      = in_valid_ff && out_free;
   assign in_free   = !in_valid_ff || eval;
   assign req_stall = !in_free;
   assign req_take  = req_valid && in_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         if (in_free) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (eval) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.opcode         <= req_opcode;
         in_ff.now_ms         <= req_now_ms;
         in_ff.frame_length   <= req_frame_length;
         in_ff.flags_byte     <= req_flags_byte;
         in_ff.throttle_byte  <= req_throttle_byte;
         in_ff.steer_low      <= req_steer_low;
         in_ff.steer_high     <= req_steer_high;
         in_ff.sequence_byte  <= req_sequence_byte;
         in_ff.local_throttle <= req_local_throttle;
         in_ff.local_steer    <= req_local_steer;
      end
      if (eval) begin
         rsp_ff <= res_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_status    = rsp_ff.frame_status;
   assign rsp_remote_active   = rsp_ff.remote_active;
   assign rsp_throttle_out    = rsp_ff.throttle_out;
   assign rsp_steer_out       = rsp_ff.steer_out;
   assign rsp_accepted_count  = rsp_ff.accepted_count;
   assign rsp_rejected_count  = rsp_ff.rejected_count;
   assign rsp_last_rx_time    = rsp_ff.last_rx_time;
   assign rsp_last_sequence   = rsp_ff.last_sequence;
   assign rsp_last_flag       = rsp_ff.last_flag;

   // a frame bumps exactly one of the two counters
   a_frame_counts: assert property (@(posedge clock) disable iff (reset)
      eval && in_ff.opcode == OP_FRAME |=>
         32'(st_ff.accept_count + st_ff.reject_count) ==
         32'($past(st_ff.accept_count + st_ff.reject_count) + 32'd1))
      else $error("frame did not bump exactly one counter");

   a_query_no_change: assert property (@(posedge clock) disable iff (reset)
      eval && in_ff.opcode == OP_QUERY |=> $stable(st_ff))
      else $error("query changed latched state");

   a_active_needs_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.remote_active |-> rsp_ff.last_flag && cfg.override_enable)
      else $error("override active without latched flag");

   a_accept_latches: assert property (@(posedge clock) disable iff (reset)
      eval && res_in.frame_status == STATUS_ACCEPT |=>
         st_ff.sequence_known && st_ff.rx_time == $past(in_ff.now_ms))
      else $error("accepted frame not latched");

endmodule

>>> bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ofa_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_opcode = OP_QUERY;
   logic [31:0]        req_now_ms = '0;
   logic [3:0]         req_frame_length = '0;
   logic [7:0]         req_flags_byte = '0;
   logic [7:0]         req_throttle_byte = '0;
   logic [7:0]         req_steer_low = '0;
   logic [7:0]         req_steer_high = '0;
   logic [7:0]         req_sequence_byte = '0;
   logic [9:0]         req_local_throttle = '0;
   logic signed [15:0] req_local_steer = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_frame_status;
   logic               rsp_remote_active;
   logic [9:0]         rsp_throttle_out;
   logic signed [15:0] rsp_steer_out;
   logic [31:0]        rsp_accepted_count;
   logic [31:0]        rsp_rejected_count;
   logic [31:0]        rsp_last_rx_time;
   logic [7:0]         rsp_last_sequence;
   logic               rsp_last_flag;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   override_frame_arbiter_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_now_ms          (req_now_ms),
      .req_frame_length    (req_frame_length),
      .req_flags_byte      (req_flags_byte),
      .req_throttle_byte   (req_throttle_byte),
      .req_steer_low       (req_steer_low),
      .req_steer_high      (req_steer_high),
      .req_sequence_byte   (req_sequence_byte),
      .req_local_throttle  (req_local_throttle),
      .req_local_steer     (req_local_steer),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_remote_active   (rsp_remote_active),
      .rsp_throttle_out    (rsp_throttle_out),
      .rsp_steer_out       (rsp_steer_out),
      .rsp_accepted_count  (rsp_accepted_count),
      .rsp_rejected_count  (rsp_rejected_count),
      .rsp_last_rx_time    (rsp_last_rx_time),
      .rsp_last_sequence   (rsp_last_sequence),
      .rsp_last_flag       (rsp_last_flag),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   item_type   outbound_items[$];
   result_type predicted_results[$];
   int         outstanding = 0;
   int         mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit         req_taken = 1'b0;
   int         burst_left = 1;
   int         gap_left = 0;
   int         stall_mode = 0;
   int         stall_run = 0;
   logic [31:0] gen_now = '0;
   logic [7:0]  gen_seq = '0;

   cfg_type   arb_cfg;
   state_type arb_state;

   function automatic result_type arbitrate(input item_type it);
      result_type         r;
      logic signed [15:0] deg;
      logic [7:0]         delta;
      logic [31:0]        elapsed;
      logic               good;
      deg = {it.steer_high, it.steer_low};
      r.frame_status = STATUS_QUERY;
      if (it.opcode == OP_FRAME) begin
         delta = it.sequence_byte - arb_state.held_sequence;
         good = arb_cfg.override_enable && it.frame_length == arb_cfg.expected_length &&
                (it.flags_byte & FLAG_RSVD_MASK) == 8'h00 && it.throttle_byte <= THR_MAX &&
                deg >= STEER_MIN && deg <= STEER_MAX;
         // sequence must advance only when override is requested on a known sequence
         if (it.flags_byte[0] && arb_state.sequence_known &&
             (delta == 8'h00 || delta > SEQ_DELTA_MAX))
            good = 1'b0;
         if (good) begin
            arb_state.held_flag      = it.flags_byte[0];
            arb_state.held_throttle  = it.throttle_byte[6:0];
            arb_state.held_steer     = deg[9:0];
            arb_state.held_sequence  = it.sequence_byte;
            arb_state.sequence_known = 1'b1;
            arb_state.rx_time        = it.now_ms;
            arb_state.accept_count   = arb_state.accept_count + 32'd1;
            r.frame_status = STATUS_ACCEPT;
         end else begin
            arb_state.reject_count = arb_state.reject_count + 32'd1;
            r.frame_status = STATUS_REJECT;
         end
      end
      elapsed = it.now_ms - arb_state.rx_time;
      r.remote_active = arb_cfg.override_enable && arb_state.sequence_known &&
                        arb_state.held_flag && elapsed < 32'(arb_cfg.timeout_ms);
      if (r.remote_active) begin
         r.throttle_out = 10'(arb_state.held_throttle * 10);
         r.steer_out    = {{6{arb_state.held_steer[9]}}, arb_state.held_steer};
      end else begin
         r.throttle_out = it.local_throttle;
         r.steer_out    = it.local_steer;
      end
      r.accepted_count = arb_state.accept_count;
      r.rejected_count = arb_state.reject_count;
      r.last_rx_time   = arb_state.rx_time;
      r.last_sequence  = arb_state.held_sequence;
      r.last_flag      = arb_state.held_flag;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // predictor: tracks register writes and accepted transactions
   always @(posedge clock) begin
      item_type it;
      if (reset) begin
         arb_state = '0;
         arb_cfg.override_enable = RESET_OVERRIDE_ENABLE;
         arb_cfg.timeout_ms      = RESET_TIMEOUT_MS;
         arb_cfg.expected_length = RESET_EXPECTED_LENGTH;
         req_taken <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OVERRIDE_ENABLE: arb_cfg.override_enable = csr_wdata[0];
               CSR_TIMEOUT_MS:      arb_cfg.timeout_ms = csr_wdata;
               CSR_EXPECTED_LENGTH: arb_cfg.expected_length = csr_wdata[3:0];
               default: ;
            endcase
         end
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            it.opcode         = req_opcode;
            it.now_ms         = req_now_ms;
            it.frame_length   = req_frame_length;
            it.flags_byte     = req_flags_byte;
            it.throttle_byte  = req_throttle_byte;
            it.steer_low      = req_steer_low;
            it.steer_high     = req_steer_high;
            it.sequence_byte  = req_sequence_byte;
            it.local_throttle = req_local_throttle;
            it.local_steer    = req_local_steer;
            predicted_results.push_back(arbitrate(it));
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_results.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: result with no transaction outstanding", $time);
         end else begin
            want = predicted_results.pop_front();
            outstanding--;
            check_field("frame_status", 32'(want.frame_status), 32'(rsp_frame_status));
            check_field("remote_active", 32'(want.remote_active),
                        32'(rsp_remote_active));
            check_field("throttle_out", 32'(want.throttle_out), 32'(rsp_throttle_out));
            check_field("steer_out", 32'(want.steer_out), 32'(rsp_steer_out));
            check_field("accepted_count", want.accepted_count, rsp_accepted_count);
            check_field("rejected_count", want.rejected_count, rsp_rejected_count);
            check_field("last_rx_time", want.last_rx_time, rsp_last_rx_time);
            check_field("last_sequence", 32'(want.last_sequence), 32'(rsp_last_sequence));
            check_field("last_flag", 32'(want.last_flag), 32'(rsp_last_flag));
         end
      end
   end

   // driver: bursts with random gaps
   always @(negedge clock) begin
      item_type nxt;
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (outbound_items.size() != 0) begin
            nxt = outbound_items.pop_front();
            req_valid          <= 1'b1;
            req_opcode         <= nxt.opcode;
            req_now_ms         <= nxt.now_ms;
            req_frame_length   <= nxt.frame_length;
            req_flags_byte     <= nxt.flags_byte;
            req_throttle_byte  <= nxt.throttle_byte;
            req_steer_low      <= nxt.steer_low;
            req_steer_high     <= nxt.steer_high;
            req_sequence_byte  <= nxt.sequence_byte;
            req_local_throttle <= nxt.local_throttle;
            req_local_steer    <= nxt.local_steer;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_run = $urandom_range(10, 150);
      end else begin
         stall_run--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         default: rsp_stall <= ($urandom_range(0, 99) < 75);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic enqueue(input item_type it);
      outbound_items.push_back(it);
      outstanding++;
   endtask

   task automatic add_frame(input logic [31:0] at, input logic [3:0] len,
                            input logic [7:0] flags, input logic [7:0] thr,
                            input logic [15:0] steer, input logic [7:0] seq);
      item_type it;
      it.opcode         = OP_FRAME;
      it.now_ms         = at;
      it.frame_length   = len;
      it.flags_byte     = flags;
      it.throttle_byte  = thr;
      it.steer_low      = steer[7:0];
      it.steer_high     = steer[15:8];
      it.sequence_byte  = seq;
      it.local_throttle = 10'($urandom_range(0, 1000));
      it.local_steer    = 16'($urandom);
      enqueue(it);
   endtask

   task automatic add_query(input logic [31:0] at, input logic [9:0] thr,
                            input logic [15:0] steer);
      item_type it;
      it.opcode         = OP_QUERY;
      it.now_ms         = at;
      it.frame_length   = 4'($urandom);
      it.flags_byte     = 8'($urandom);
      it.throttle_byte  = 8'($urandom);
      it.steer_low      = 8'($urandom);
      it.steer_high     = 8'($urandom);
      it.sequence_byte  = 8'($urandom);
      it.local_throttle = thr;
      it.local_steer    = steer;
      enqueue(it);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input logic en, input logic [15:0] tmo, input logic [3:0] len,
                            input logic [31:0] start_at, input int count);
      item_type    it;
      int          pick;
      int          span;
      logic [15:0] steer;
      logic [7:0]  delta;
      write_reg(CSR_OVERRIDE_ENABLE, {15'b0, en});
      write_reg(CSR_TIMEOUT_MS, tmo);
      write_reg(CSR_EXPECTED_LENGTH, {12'b0, len});
      span = (tmo == 16'd0) ? 1000 : int'(tmo);
      gen_now = start_at;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            gen_now += $urandom_range(0, span / 4);
         else if (pick < 75)
            gen_now += $urandom_range(0, span + 2);
         else if (pick < 95)
            gen_now += $urandom_range(span - 1, span + 1);
         else
            gen_now = $urandom;
         pick = $urandom_range(0, 99);
         steer = 16'(int'($urandom_range(0, 600)) - 300);
         delta = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 256))
                                              : 8'($urandom_range(1, 127));
         it.opcode         = OP_FRAME;
         it.now_ms         = gen_now;
         it.frame_length   = len;
         it.flags_byte     = {7'b0, ($urandom_range(0, 9) < 8)};
         it.throttle_byte  = 8'($urandom_range(0, 100));
         it.steer_low      = steer[7:0];
         it.steer_high     = steer[15:8];
         it.sequence_byte  = gen_seq + delta;
         it.local_throttle = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                         : 10'($urandom_range(0, 1000));
         it.local_steer    = 16'($urandom);
         if (pick < 20) begin
            it.opcode = OP_QUERY;
         end else if (pick < 75) begin
            if (!it.flags_byte[0] || (delta != 8'h00 && delta <= SEQ_DELTA_MAX))
               gen_seq = it.sequence_byte;
         end else if (pick < 90) begin
            case ($urandom_range(0, 3))
               0: it.frame_length = len + 4'($urandom_range(1, 15));
               1: it.flags_byte = it.flags_byte | 8'($urandom_range(1, 127) << 1);
               2: it.throttle_byte = 8'($urandom_range(101, 255));
               default: begin
                  steer = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(301, 32767))
                                                      : 16'(-int'($urandom_range(301, 32768)));
                  it.steer_low  = steer[7:0];
                  it.steer_high = steer[15:8];
               end
            endcase
         end else begin
            it.opcode        = logic'($urandom_range(0, 1));
            it.now_ms        = $urandom;
            it.frame_length  = 4'($urandom);
            it.flags_byte    = 8'($urandom);
            it.throttle_byte = 8'($urandom);
            it.steer_low     = 8'($urandom);
            it.steer_high    = 8'($urandom);
            it.sequence_byte = 8'($urandom);
         end
         enqueue(it);
      end
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset configuration
      add_query(32'd0, 10'd0, 16'h8000);
      add_query(32'd0, 10'd1023, 16'h7FFF);
      add_frame(32'd1000, 4'd5, 8'h01, 8'd100, 16'd300, 8'd10);
      add_query(32'd1499, 10'd5, 16'd5);
      add_query(32'd1500, 10'd5, 16'd5);
      add_frame(32'd1500, 4'd5, 8'h01, 8'd20, 16'd0, 8'd10);
      add_frame(32'd1500, 4'd5, 8'h01, 8'd20, 16'd0, 8'd138);
      add_frame(32'd1600, 4'd5, 8'h01, 8'd0, -16'sd300, 8'd137);
      add_frame(32'd1600, 4'd5, 8'h01, 8'd101, 16'd0, 8'd138);
      add_frame(32'd1600, 4'd5, 8'h01, 8'd10, 16'd301, 8'd138);
      add_frame(32'd1600, 4'd5, 8'h01, 8'd10, -16'sd301, 8'd138);
      add_frame(32'd1600, 4'd5, 8'h03, 8'd10, 16'd0, 8'd138);
      add_frame(32'd1600, 4'd5, 8'h81, 8'd10, 16'd0, 8'd138);
      add_frame(32'd1600, 4'd4, 8'h01, 8'd10, 16'd0, 8'd138);
      add_frame(32'd1600, 4'd15, 8'h01, 8'd10, 16'd0, 8'd138);
      add_frame(32'd1700, 4'd5, 8'h00, 8'd50, 16'd0, 8'd137);
      add_query(32'd1710, 10'd1001, 16'd77);
      add_frame(32'd1800, 4'd5, 8'h01, 8'd7, 16'hFFFF, 8'd138);
      add_query(32'd1799, 10'd300, -16'sd77);
      add_frame(32'd1900, 4'd5, 8'hFF, 8'd255, 16'h7FFF, 8'd0);
      add_frame(32'd2000, 4'd5, 8'h01, 8'd1, 16'd1, 8'd9);
      add_query(32'd2000, 10'd0, 16'd0);
      drain();
      gen_seq = 8'd9;

      run_phase(1'b1, 16'd500, 4'd5, 32'd3000, 218);
      run_phase(1'b1, 16'd1, 4'd5, 32'h0010_0000, 218);
      run_phase(1'b1, 16'hFFFF, 4'd8, 32'h0200_0000, 218);
      run_phase(1'b0, 16'd500, 4'd5, 32'h0300_0000, 218);
      run_phase(1'b1, 16'd0, 4'd0, 32'h8000_0000, 218);
      run_phase(1'b1, 16'd200, 4'd15, 32'hC000_0000, 218);
      run_phase(1'b1, 16'd3000, 4'd5, 32'hFFFF_F000, 218);

      if (mismatch_count == 0 && predicted_results.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
